>>> hw/rtl/sida_pkg.sv
package sida_pkg;

  localparam int MAG_W = 64;
  localparam int CNT_W = $clog2(MAG_W);
  localparam int DIG_N = 20;
  localparam int BCD_W = 4 * DIG_N;
  localparam int NDIG_W = $clog2(DIG_N + 1);
  localparam int PAD_W = 6;
  localparam int LEN_W = 6;
  localparam int CHAR_W = 7;
  localparam int MAX_PAD = 32;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  typedef struct packed {
    logic load;
    logic dig_shift;
  } sida_bcd_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [3:0] top_digit;
  } sida_bcd_stat_t;

endpackage

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Converts a signed 64-bit integer to decimal ASCII text, one character per
// result transfer, most significant first: a minus sign for a negative value,
// then in_zero_pad '0' characters (saturated at 32), then the digits of the
// magnitude without leading zeros. A zero value with a zero count gives "0".
// An input transfer happens at a clock edge with start high and busy low.
// Each character is on out_character for exactly one cycle while out_strobe
// is high; out_last marks the final character, and out_length then carries
// the character count (it is zero on every other character).
// The magnitude goes through a bit-serial shift-and-add-3 converter that
// takes one input bit per cycle. Leading zero digits are then dropped at
// one digit per cycle (20 minus the digit count of the magnitude), and
// the characters follow one per cycle, up to 52 of them. Busy falls at
// the same clock edge at which the last character goes onto the outputs,
// and the next input transfer can come at the end of that cycle.
// The receiver cannot stall, so nothing waits on the result side.
// A synchronous reset with rst_n low returns the block to idle and drops
// any conversion in progress.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [MAG_W-1:0] in_value,
  input  logic [PAD_W-1:0]        in_zero_pad,
  output logic                    out_strobe,
  output logic [CHAR_W-1:0]       out_character,
  output logic                    out_last,
  output logic [LEN_W-1:0]        out_length
);

  logic             accept;
  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [PAD_W-1:0] pad_sat;
  logic [PAD_W-1:0] pad;
  sida_bcd_ctrl_t   ctrl;
  sida_bcd_stat_t   stat;

  assign accept  = start && !busy;
  assign neg     = in_value[MAG_W-1];
  assign mag     = neg ? (~in_value + 1'b1) : in_value;
  assign pad_sat = (in_zero_pad > PAD_W'(MAX_PAD)) ? PAD_W'(MAX_PAD) : in_zero_pad;
  assign pad     = (mag == '0 && pad_sat == '0) ? PAD_W'(1) : pad_sat;

  sida_bcd u_bcd (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (ctrl),
    .mag  (mag),
    .stat (stat)
  );

  sida_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .neg      (neg),
    .pad      (pad),
    .stat     (stat),
    .ctrl     (ctrl),
    .busy     (busy),
    .strobe   (out_strobe),
    .character(out_character),
    .last     (out_last),
    .length   (out_length)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy did not rise after an input transfer");

  a_strobe_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("character strobed outside a conversion");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("character strobed right after the last one");

  a_length_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> out_length == '0)
    else $error("length set on a character that is not the last");
`endif

endmodule

>>> hw/rtl/sida_bcd.sv
module sida_bcd
  import sida_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  sida_bcd_ctrl_t   ctrl,
  input  logic [MAG_W-1:0] mag,
  output sida_bcd_stat_t   stat
);

  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BCD_W-1:0] bcd_adj;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;

  // Shift-and-add-3: every digit of five or more is corrected before the shift.
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    priority if (ctrl.load) begin
      mag_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[MAG_W-1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MAG_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      bcd_nxt = ctrl.dig_shift ? {bcd_r[BCD_W-5:0], 4'd0} : bcd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
  end

  assign stat.done      = done_r;
  assign stat.top_digit = bcd_r[BCD_W-1 -: 4];

endmodule

>>> hw/rtl/sida_emit.sv
module sida_emit
  import sida_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              neg,
  input  logic [PAD_W-1:0]  pad,
  input  sida_bcd_stat_t    stat,
  output sida_bcd_ctrl_t    ctrl,
  output logic              busy,
  output logic              strobe,
  output logic [CHAR_W-1:0] character,
  output logic              last,
  output logic [LEN_W-1:0]  length
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_DIG  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic              neg_r, neg_nxt;
  logic [PAD_W-1:0]  pad_r, pad_nxt;
  logic [NDIG_W-1:0] ndig_r, ndig_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              strobe_r, strobe_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic [LEN_W-1:0]  olen_r, olen_nxt;
  logic              dig_shift;

  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    pad_nxt    = pad_r;
    ndig_nxt   = ndig_r;
    len_nxt    = len_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = 1'b0;
    olen_nxt   = '0;
    dig_shift  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_CONV;
          neg_nxt   = neg;
          pad_nxt   = pad;
          ndig_nxt  = NDIG_W'(DIG_N);
          len_nxt   = LEN_W'(pad) + LEN_W'(neg);
        end
      end
      ST_CONV: begin
        if (stat.done) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (ndig_r != '0 && stat.top_digit == 4'd0) begin
          dig_shift = 1'b1;
          ndig_nxt  = ndig_r - 1'b1;
        end else begin
          len_nxt = len_r + LEN_W'(ndig_r);
          priority if (neg_r) begin
            state_nxt = ST_SIGN;
          end else if (pad_r != '0) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_DIG;
          end
        end
      end
      ST_SIGN: begin
        strobe_nxt = 1'b1;
        char_nxt   = CHAR_MINUS;
        state_nxt  = (pad_r != '0) ? ST_PAD : ST_DIG;
      end
      ST_PAD: begin
        strobe_nxt = 1'b1;
        char_nxt   = CHAR_ZERO;
        pad_nxt    = pad_r - 1'b1;
        if (pad_r == PAD_W'(1)) begin
          if (ndig_r == '0) begin
            state_nxt = ST_IDLE;
            last_nxt  = 1'b1;
            olen_nxt  = len_r;
          end else begin
            state_nxt = ST_DIG;
          end
        end
      end
      ST_DIG: begin
        strobe_nxt = 1'b1;
        char_nxt   = CHAR_ZERO | {3'd0, stat.top_digit};
        dig_shift  = 1'b1;
        ndig_nxt   = ndig_r - 1'b1;
        if (ndig_r == NDIG_W'(1)) begin
          state_nxt = ST_IDLE;
          last_nxt  = 1'b1;
          olen_nxt  = len_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
    neg_r  <= neg_nxt;
    pad_r  <= pad_nxt;
    ndig_r <= ndig_nxt;
    len_r  <= len_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    olen_r <= olen_nxt;
  end

  assign ctrl.load      = load;
  assign ctrl.dig_shift = dig_shift;
  assign busy           = (state_r != ST_IDLE);
  assign strobe         = strobe_r;
  assign character      = char_r;
  assign last           = last_r;
  assign length         = olen_r;

endmodule

>>> bench/signed_int_to_decimal_ascii_test.sv
module signed_int_to_decimal_ascii_test;
  import sida_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int MAX_CHARS = 52;
  localparam int TEXT_W = 8 * MAX_CHARS;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic [LEN_W-1:0]  length;
  } ascii_char_t;

  typedef struct packed {
    logic [MAG_W-1:0]  value;
    logic [PAD_W-1:0]  pad;
    logic [TEXT_W-1:0] text;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [MAG_W-1:0] in_value;
  logic [PAD_W-1:0]        in_zero_pad;
  logic                    out_strobe;
  logic [CHAR_W-1:0]       out_character;
  logic                    out_last;
  logic [LEN_W-1:0]        out_length;

  logic [TEXT_W-1:0] typed_text;
  ascii_char_t       expected_chars[$];
  int                fault_count;
  int                transfer_count;
  int unsigned       idle_pct;

  // Rows with a nonzero text field carry the exact expected string.
  stim_row_t dir_rows [0:20] = '{
    '{64'd0, 6'd0, TEXT_W'("0")},
    '{64'd0, 6'd5, TEXT_W'("00000")},
    '{64'd0, 6'd32, '0},
    '{64'd0, 6'd63, '0},
    '{64'd0, 6'd33, '0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 6'd0, TEXT_W'("9223372036854775807")},
    '{64'h8000_0000_0000_0000, 6'd0, TEXT_W'("-9223372036854775808")},
    '{64'h8000_0000_0000_0000, 6'd32, '0},
    '{64'h8000_0000_0000_0000, 6'd63, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 6'd0, TEXT_W'("-1")},
    '{64'd1, 6'd0, TEXT_W'("1")},
    '{64'hFFFF_FFFF_FFFF_FFF6, 6'd3, TEXT_W'("-00010")},
    '{64'd10, 6'd1, '0},
    '{64'd9, 6'd0, '0},
    '{64'h8000_0000_0000_0001, 6'd0, '0},
    '{64'h5555_5555_5555_5555, 6'h15, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 6'h2A, '0},
    '{64'd1000000000000000000, 6'd2, '0},
    '{64'd999999999999999999, 6'd0, '0},
    '{64'hFFFF_FFFF_FFFF_FF9C, 6'd31, '0},
    '{64'd12345678901234567, 6'd7, '0}
  };

  signed_int_to_decimal_ascii dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_zero_pad  (in_zero_pad),
    .out_strobe   (out_strobe),
    .out_character(out_character),
    .out_last     (out_last),
    .out_length   (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // The text is right-justified, one ASCII byte per character, first character highest.
  function automatic logic [TEXT_W-1:0] decimal_text(input logic [MAG_W-1:0] raw,
                                                     input logic [PAD_W-1:0] pad);
    logic [TEXT_W-1:0] txt;
    logic [MAG_W-1:0]  mag;
    logic [3:0]        digits [0:DIG_N-1];
    int                ndig;
    int                zeros;
    txt = '0;
    ndig = 0;
    mag = raw[MAG_W-1] ? (~raw + 1'b1) : raw;
    zeros = (pad > MAX_PAD) ? MAX_PAD : int'(pad);
    if (mag == 0 && zeros == 0) begin
      zeros = 1;
    end
    while (mag != 0) begin
      digits[ndig] = 4'(mag % 10);
      mag = mag / 10;
      ndig++;
    end
    if (raw[MAG_W-1]) begin
      txt = {txt[TEXT_W-9:0], 1'b0, CHAR_MINUS};
    end
    repeat (zeros) txt = {txt[TEXT_W-9:0], 1'b0, CHAR_ZERO};
    while (ndig > 0) begin
      ndig--;
      txt = {txt[TEXT_W-9:0], 1'b0, CHAR_ZERO + CHAR_W'(digits[ndig])};
    end
    return txt;
  endfunction

  task automatic queue_text(input logic [TEXT_W-1:0] txt);
    int n;
    n = 0;
    for (int i = 0; i < MAX_CHARS; i++) begin
      if (txt[8*i +: 8] != 8'd0) begin
        n = i + 1;
      end
    end
    for (int i = n - 1; i >= 0; i--) begin
      expected_chars.push_back('{txt[8*i +: CHAR_W], i == 0, (i == 0) ? LEN_W'(n) : '0});
    end
  endtask

  task automatic report_fault(input string msg);
    if (fault_count < 10) begin
      $display("%s", msg);
    end
    fault_count++;
  endtask

  always @(posedge clk) begin : check_output
    ascii_char_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_chars.size() == 0) begin
          report_fault($sformatf("unexpected character %0d last %0d length %0d",
                                 out_character, out_last, out_length));
        end else begin
          want = expected_chars.pop_front();
          if (out_character !== want.character || out_last !== want.last ||
              out_length !== want.length) begin
            report_fault($sformatf(
              "mismatch: expected char %0d last %0d length %0d, got char %0d last %0d length %0d",
              want.character, want.last, want.length, out_character, out_last, out_length));
          end
        end
      end
      if (start && !busy) begin
        queue_text((typed_text != '0) ? typed_text : decimal_text(in_value, in_zero_pad));
        transfer_count++;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_conversion(input logic [MAG_W-1:0] v, input logic [PAD_W-1:0] p,
                                 input logic [TEXT_W-1:0] txt);
    int seen;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_value = v;
    in_zero_pad = p;
    typed_text = txt;
    seen = transfer_count;
    while (transfer_count == seen) @(negedge clk);
  endtask

  initial begin
    #(CLK_PERIOD * 1000000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned      idle_plan [0:4];
    logic [MAG_W-1:0] mag;
    logic [PAD_W-1:0] pad;
    int               kind;
    idle_plan = '{0, 47, 7, 0, 47};
    start = 1'b0;
    in_value = '0;
    in_zero_pad = '0;
    typed_text = '0;
    fault_count = 0;
    transfer_count = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_conversion(dir_rows[i].value, dir_rows[i].pad, dir_rows[i].text);
    end

    foreach (idle_plan[ph]) begin
      idle_pct = idle_plan[ph];
      repeat (80) begin
        kind = $urandom_range(0, 9);
        mag = '0;
        case (kind)
          0, 1, 2: mag = {$urandom, $urandom};
          3, 4, 5: begin
            mag = MAG_W'($urandom_range(1, 9));
            repeat ($urandom_range(0, 18)) mag = mag * 10 + MAG_W'($urandom_range(0, 9));
          end
          6: begin
            mag = MAG_W'(1);
            repeat ($urandom_range(0, 18)) mag = mag * 10;
            mag = mag + MAG_W'($urandom_range(0, 2)) - 1;
          end
          7: mag = '0;
          8: mag = 64'h7FFF_FFFF_FFFF_FFFF - MAG_W'($urandom_range(0, 2));
          default: mag = MAG_W'($urandom_range(0, 99));
        endcase
        if ($urandom_range(0, 1) == 1) begin
          mag = ~mag + 1'b1;
        end
        pad = ($urandom_range(0, 3) == 0) ? PAD_W'($urandom_range(0, 63))
                                          : PAD_W'($urandom_range(0, 3));
        send_conversion(mag, pad, '0);
      end
    end
    start = 1'b0;

    while (expected_chars.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (expected_chars.size() != 0) begin
      report_fault($sformatf("%0d characters never arrived", expected_chars.size()));
    end
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sida_pkg.sv
hw/rtl/sida_bcd.sv
hw/rtl/sida_emit.sv
hw/rtl/signed_int_to_decimal_ascii.sv
bench/signed_int_to_decimal_ascii_test.sv
